// File: rtl/core/point_in_polygon_crossing_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-polygon block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_CROSSING_TOP_ASSERT_SVH
`define POINT_IN_POLYGON_CROSSING_TOP_ASSERT_SVH

// property must hold at every edge out of reset
`define PIP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define PIP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants and types of the point-in-polygon crossing block.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned MID_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH  = 4;

  // per-request control from front to back
  typedef struct packed {
    logic first;
    logic last;
    logic a_vld;   // edge prev -> vertex straddles the line
    logic a_up;    // edge prev -> vertex rises
    logic b_vld;   // closing edge straddles the line (last only)
    logic b_up;
  } pip_ctrl_t;

endpackage

// File: rtl/core/point_in_polygon_crossing_top.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_top
// Even-odd point-in-polygon test over a stream of signed polygon vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): one vertex per request with the query point.
//   first_vertex_i opens a polygon and latches the query point; later
//   vertices test the edge from the previous vertex. last_vertex_i also
//   tests the closing edge and produces one inside bit.
//   Output queue (empty/pop): inside_res_o is valid while empty is low.
// Path: a last vertex passes the operand queue, the product register and the
//   result queue before its result shows.
// Throughput: one vertex per cycle while the result queue has room; four parallel
//   cross-product multipliers in the back end each take one pipeline stage.
// Reset: coordinates, start, previous vertex and parity clear to zero,
//   both queues empty.
// Stall: a slow consumer fills the result queue, the back end stops taking
//   requests from the operand queue, and full rises once that fills.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_top #(
  parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS,
  parameter int unsigned MID_DEPTH  = pip_pkg::MID_DEPTH,
  parameter int unsigned OUT_DEPTH  = pip_pkg::OUT_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic                         first_vertex_i,
  input  logic                         last_vertex_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         inside_res_o
);

  localparam int unsigned CW        = COORD_BITS + 1;
  localparam int unsigned CTRL_W    = $bits(pip_pkg::pip_ctrl_t);
  localparam int unsigned MID_W     = CTRL_W + 8 * CW;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  logic                   accept;
  pip_pkg::pip_ctrl_t     fr_ctrl, mid_ctrl;
  logic [8*CW-1:0]        fr_ops, mid_ops;
  logic [MID_W-1:0]       mid_data;
  logic                   mid_empty, mid_pop;
  logic [OUT_CNT_W-1:0]   out_cnt;
  logic                   out_push, out_data, out_full;

  assign accept = push && !full;

  pip_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .query_x_i,
    .query_y_i,
    .vertex_x_i,
    .vertex_y_i,
    .first_vertex_i,
    .last_vertex_i,
    .ctrl_o         (fr_ctrl),
    .ops_o          (fr_ops)
  );

  pip_fifo #(
    .WIDTH(MID_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (accept),
    .data_i  ({fr_ctrl, fr_ops}),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty),
    .full_o  (full),
    .count_o ()
  );

  assign mid_ctrl = pip_pkg::pip_ctrl_t'(mid_data[MID_W-1 -: CTRL_W]);
  assign mid_ops  = mid_data[8*CW-1:0];

  pip_back #(
    .COORD_BITS(COORD_BITS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .mid_empty_i (mid_empty),
    .mid_ctrl_i  (mid_ctrl),
    .mid_ops_i   (mid_ops),
    .mid_pop_o   (mid_pop),
    .out_cnt_i   (out_cnt),
    .out_push_o  (out_push),
    .out_data_o  (out_data)
  );

  pip_fifo #(
    .WIDTH(1),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (out_push),
    .data_i  (out_data),
    .pop_i   (pop),
    .data_o  (inside_res_o),
    .empty_o (empty),
    .full_o  (out_full),
    .count_o (out_cnt)
  );

`include "point_in_polygon_crossing_top_assert.svh"

  // the back end reserves a result slot before issuing, so no result is dropped
  `PIP_ASSERT_NEVER(a_out_no_overflow, out_push && out_full, "result queue overflow")
  `PIP_ASSERT(a_mid_pop_valid, mid_pop |-> !mid_empty, "operand queue read while empty")
  `PIP_ASSERT(a_result_from_last, out_push |-> $past(mid_pop && mid_ctrl.last),
              "result without a last vertex")

endmodule

// File: rtl/core/pip_fifo.sv
// ----------------------------------------------------------------------------
// pip_fifo
// Small show-ahead flip-flop queue with occupancy count.
// ----------------------------------------------------------------------------
module pip_fifo #(
  parameter  int unsigned WIDTH = 1,
  parameter  int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o,
  output logic [CNT_W-1:0] count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/pip_front.sv
// ----------------------------------------------------------------------------
// pip_front
// Keeps query point, start and previous vertex; classifies the edges of
// each accepted vertex and forms the operand differences for the back end.
// ----------------------------------------------------------------------------
module pip_front #(
  parameter  int unsigned COORD_BITS = pip_pkg::COORD_BITS,
  localparam int unsigned CW         = COORD_BITS + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic signed [COORD_BITS-1:0]  query_x_i,
  input  logic signed [COORD_BITS-1:0]  query_y_i,
  input  logic signed [COORD_BITS-1:0]  vertex_x_i,
  input  logic signed [COORD_BITS-1:0]  vertex_y_i,
  input  logic                          first_vertex_i,
  input  logic                          last_vertex_i,
  output pip_pkg::pip_ctrl_t            ctrl_o,
  output logic        [8*CW-1:0]        ops_o
);

  logic signed [COORD_BITS-1:0] point_x_q, point_y_q;
  logic signed [COORD_BITS-1:0] start_x_q, start_y_q;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;

  logic signed [COORD_BITS-1:0] pt_x, pt_y, st_x, st_y;
  logic signed [CW-1:0]         a_a, a_b, a_c, a_d;
  logic signed [CW-1:0]         b_a, b_b, b_c, b_d;

  // a first vertex sees the new point and start on its closing edge
  assign pt_x = first_vertex_i ? query_x_i  : point_x_q;
  assign pt_y = first_vertex_i ? query_y_i  : point_y_q;
  assign st_x = first_vertex_i ? vertex_x_i : start_x_q;
  assign st_y = first_vertex_i ? vertex_y_i : start_y_q;

  // edge prev -> vertex: x-xi, yj-yi, y-yi, xj-xi
  assign a_a = CW'(point_x_q)  - CW'(prev_x_q);
  assign a_b = CW'(vertex_y_i) - CW'(prev_y_q);
  assign a_c = CW'(point_y_q)  - CW'(prev_y_q);
  assign a_d = CW'(vertex_x_i) - CW'(prev_x_q);

  // closing edge vertex -> start
  assign b_a = CW'(pt_x) - CW'(vertex_x_i);
  assign b_b = CW'(st_y) - CW'(vertex_y_i);
  assign b_c = CW'(pt_y) - CW'(vertex_y_i);
  assign b_d = CW'(st_x) - CW'(vertex_x_i);

  assign ops_o = {a_a, a_b, a_c, a_d, b_a, b_b, b_c, b_d};

  always_comb begin
    ctrl_o       = '0;
    ctrl_o.first = first_vertex_i;
    ctrl_o.last  = last_vertex_i;
    ctrl_o.a_vld = !first_vertex_i &&
                   ((prev_y_q > point_y_q && vertex_y_i <= point_y_q) ||
                    (vertex_y_i > point_y_q && prev_y_q <= point_y_q));
    ctrl_o.a_up  = vertex_y_i > prev_y_q;
    ctrl_o.b_vld = last_vertex_i &&
                   ((vertex_y_i > pt_y && st_y <= pt_y) ||
                    (st_y > pt_y && vertex_y_i <= pt_y));
    ctrl_o.b_up  = st_y > vertex_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q <= '0;
      point_y_q <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else if (accept_i) begin
      point_x_q <= pt_x;
      point_y_q <= pt_y;
      start_x_q <= st_x;
      start_y_q <= st_y;
      prev_x_q  <= vertex_x_i;
      prev_y_q  <= vertex_y_i;
    end
  end

endmodule

// File: rtl/core/pip_back.sv
// ----------------------------------------------------------------------------
// pip_back
// Multiplies the cross-products, compares them, keeps the crossing parity
// and pushes the inside bit on the last vertex of a polygon.
// ----------------------------------------------------------------------------
module pip_back #(
  parameter  int unsigned COORD_BITS = pip_pkg::COORD_BITS,
  parameter  int unsigned OUT_DEPTH  = pip_pkg::OUT_DEPTH,
  localparam int unsigned CW         = COORD_BITS + 1,
  localparam int unsigned PW         = 2 * CW,
  localparam int unsigned CNT_W      = $clog2(OUT_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 mid_empty_i,
  input  pip_pkg::pip_ctrl_t   mid_ctrl_i,
  input  logic [8*CW-1:0]      mid_ops_i,
  output logic                 mid_pop_o,
  input  logic [CNT_W-1:0]     out_cnt_i,
  output logic                 out_push_o,
  output logic                 out_data_o
);

  logic signed [CW-1:0] a_a, a_b, a_c, a_d, b_a, b_b, b_c, b_d;
  logic signed [PW-1:0] pa1_q, pa2_q, pb1_q, pb2_q;
  logic                 s1_vld_q;
  pip_pkg::pip_ctrl_t   s1_ctrl_q;
  logic                 parity_q, parity_d;
  logic                 cross_a, cross_b;
  logic [CNT_W:0]       pending;

  assign a_a = mid_ops_i[7*CW +: CW];
  assign a_b = mid_ops_i[6*CW +: CW];
  assign a_c = mid_ops_i[5*CW +: CW];
  assign a_d = mid_ops_i[4*CW +: CW];
  assign b_a = mid_ops_i[3*CW +: CW];
  assign b_b = mid_ops_i[2*CW +: CW];
  assign b_c = mid_ops_i[1*CW +: CW];
  assign b_d = mid_ops_i[0*CW +: CW];

  // issue only with a result slot reserved for whatever is in flight
  assign pending   = {1'b0, out_cnt_i} + (CNT_W + 1)'(s1_vld_q && s1_ctrl_q.last);
  assign mid_pop_o = !mid_empty_i && (pending < (CNT_W + 1)'(OUT_DEPTH));

  // point on or left of crossing; comparison flips for a falling edge
  assign cross_a = s1_ctrl_q.a_vld &&
                   (s1_ctrl_q.a_up ? (pa1_q <= pa2_q) : (pa1_q >= pa2_q));
  assign cross_b = s1_ctrl_q.b_vld &&
                   (s1_ctrl_q.b_up ? (pb1_q <= pb2_q) : (pb1_q >= pb2_q));

  assign parity_d   = (s1_ctrl_q.first ? 1'b0 : parity_q) ^ cross_a ^ cross_b;
  assign out_push_o = s1_vld_q && s1_ctrl_q.last;
  assign out_data_o = parity_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_ctrl_q <= '0;
      parity_q  <= 1'b0;
    end else begin
      s1_vld_q <= mid_pop_o;
      if (mid_pop_o) begin
        s1_ctrl_q <= mid_ctrl_i;
      end
      if (s1_vld_q) begin
        parity_q <= parity_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      pa1_q <= a_a * a_b;
      pa2_q <= a_c * a_d;
      pb1_q <= b_a * b_b;
      pb2_q <= b_c * b_d;
    end
  end

endmodule
